/* sv/shc_pkg.sv */
package shc_pkg;

   localparam int unsigned NUM_MOTORS = 2;
   localparam int unsigned RAMP_SHIFT = 6;

   localparam logic [15:0] RESET_TARGET  = 16'd1000;
   localparam logic [15:0] RESET_START   = 16'd2000;
   localparam logic [15:0] RESET_PULLOFF = 16'd100;

   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_MOVE  = 3'd1,
      CMD_PULL  = 3'd2,
      CMD_CCW   = 3'd3,
      CMD_CW    = 3'd4,
      CMD_STOP  = 3'd5,
      CMD_ZSTOP = 3'd6,
      CMD_QUERY = 3'd7
   } cmd_type;

   localparam logic [2:0] M_RELAX = 3'd0;
   localparam logic [2:0] M_RUN   = 3'd1;
   localparam logic [2:0] M_STOP  = 3'd2;
   localparam logic [2:0] M_ZSTOP = 3'd3;
   localparam logic [2:0] M_MOVE  = 3'd4;
   localparam logic [2:0] M_PULL  = 3'd5;

   localparam logic [1:0] D_CW      = 2'd0;
   localparam logic [1:0] D_CCW     = 2'd1;
   localparam logic [1:0] D_STOPPED = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_REJ   = 2'd1;
   localparam logic [1:0] ST_LOWER = 2'd2;
   localparam logic [1:0] ST_UPPER = 2'd3;

   localparam logic [1:0] REG_TARGET_0 = 2'd0;
   localparam logic [1:0] REG_TARGET_1 = 2'd1;
   localparam logic [1:0] REG_START    = 2'd2;
   localparam logic [1:0] REG_PULLOFF  = 2'd3;

   typedef struct packed {
      logic [2:0]  command;
      logic        motor_index;
      logic signed [31:0] step_count;
      logic [1:0]  switches_0;
      logic [1:0]  switches_1;
   } req_type;

   typedef struct packed {
      logic [3:0]  coils_0;
      logic [3:0]  coils_1;
      logic [1:0]  status;
      logic signed [31:0] position;
      logic signed [31:0] steps_remaining;
      logic [2:0]  motor_mode;
      logic [1:0]  direction;
      logic [15:0] current_period;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  dir;
      logic [31:0] steps_to_go;
      logic [31:0] pos;
      logic [31:0] steps_at_switch;
      logic [15:0] ramp_step;
      logic [2:0]  phase;
      logic [15:0] period;
      logic [15:0] countdown;
      logic [3:0]  coil_latch;
   } motor_type;

   function automatic logic [3:0] coil_of(input logic [2:0] ph);
      logic [3:0] c;
      unique case (ph)
         3'd0: c = 4'b1000;
         3'd1: c = 4'b1010;
         3'd2: c = 4'b0010;
         3'd3: c = 4'b0110;
         3'd4: c = 4'b0100;
         3'd5: c = 4'b0101;
         3'd6: c = 4'b0001;
         default: c = 4'b1001;
      endcase
      return c;
   endfunction

   function automatic logic [15:0] nz(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

endpackage

/* sv/stepper_halfstep_controller_unit.sv */
// The result of an accepted request is registered and valid in the next cycle.
// Throughput: one request per cycle; the result register stalls only when
// rsp_ready is low and the register is full, then it accepts again on take.
// Reset: synchronous, active high; motors relax, stopped, periods 1000,
// start period 2000, pull-off 100 full steps.
module stepper_halfstep_controller_unit import shc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] tgt0_ff, tgt1_ff, start_ff, pull_ff;
   logic        valid_ff;
   rsp_type     out_ff, out_in;
   logic        go;
   motor_type   s0, s1, sel;
   logic [1:0]  st0, st1;

   assign req_ready = !valid_ff || rsp_ready;
   assign go = req_valid && req_ready;

   shc_motor u_m0 (
      .clock, .reset, .go, .command(req_data.command),
      .selected(req_data.motor_index == 1'b0), .count(req_data.step_count),
      .sw(req_data.switches_0), .target(tgt0_ff), .start(start_ff),
      .pulloff(pull_ff), .cfg_load(csr_we && csr_index == REG_TARGET_0),
      .cfg_value(csr_wdata), .next_state(s0), .status(st0));
   shc_motor u_m1 (
      .clock, .reset, .go, .command(req_data.command),
      .selected(req_data.motor_index == 1'b1), .count(req_data.step_count),
      .sw(req_data.switches_1), .target(tgt1_ff), .start(start_ff),
      .pulloff(pull_ff), .cfg_load(csr_we && csr_index == REG_TARGET_1),
      .cfg_value(csr_wdata), .next_state(s1), .status(st1));

   // The result reflects the state after this request; rebuild it from next values.
   always_comb begin
      sel = req_data.motor_index ? s1 : s0;
      out_in.coils_0 = s0.coil_latch;
      out_in.coils_1 = s1.coil_latch;
      out_in.status = req_data.motor_index ? st1 : st0;
      out_in.position = sel.pos;
      out_in.steps_remaining = sel.steps_to_go;
      out_in.motor_mode = sel.mode;
      out_in.direction = sel.dir;
      out_in.current_period = sel.period;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt0_ff <= RESET_TARGET; tgt1_ff <= RESET_TARGET;
         start_ff <= RESET_START; pull_ff <= RESET_PULLOFF;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_TARGET_0: tgt0_ff <= csr_wdata;
               REG_TARGET_1: tgt1_ff <= csr_wdata;
               REG_START:    start_ff <= csr_wdata;
               default:      pull_ff <= csr_wdata;
            endcase
         end
         if (req_ready) valid_ff <= req_valid;
      end
      if (go) out_ff <= out_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |=> valid_ff && $stable(out_ff))
      else $error("result lost under stall");
   a_load: assert property (@(posedge clock) disable iff (reset)
      go |=> valid_ff) else $error("accepted request gave no result");
   a_sel: assert property (@(posedge clock) disable iff (reset)
      s0.dir != 2'd3 && s1.dir != 2'd3) else $error("bad motor state");
endmodule

/* sv/shc_motor.sv */
// One motor: timer, command action and supervision for one request.
module shc_motor import shc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [2:0]  command,
   input  logic        selected,
   input  logic [31:0] count,
   input  logic [1:0]  sw,
   input  logic [15:0] target,
   input  logic [15:0] start,
   input  logic [15:0] pulloff,
   input  logic        cfg_load,
   input  logic [15:0] cfg_value,
   output motor_type   next_state,
   output logic [1:0]  status
);

   motor_type m_ff, m_in;
   logic [15:0] tgt, sp, dec;
   logic [31:0] mag, n;
   logic        ok;
   logic signed [32:0] diff;

   always_comb begin
      m_in   = m_ff;
      status = ST_OK;
      tgt    = nz(target);
      sp     = nz(start);
      dec    = m_ff.period - m_ff.ramp_step;
      mag    = 32'd0 - count;
      if (mag == 32'h8000_0000) mag = 32'h7FFF_FFFF;
      n      = count;
      ok     = 1'b0;
      diff   = 33'sd0;
      if (go && command == CMD_TICK && m_ff.dir != D_STOPPED) begin
         if (m_ff.countdown > 16'd1) begin
            m_in.countdown = m_ff.countdown - 16'd1;
         end else begin
            if (m_ff.ramp_step != 16'd0) begin
               if (m_ff.period < m_ff.ramp_step || dec < tgt) begin
                  m_in.period = tgt;
                  m_in.ramp_step = 16'd0;
               end else begin
                  m_in.period = dec;
               end
            end
            m_in.coil_latch = coil_of(m_ff.phase);
            m_in.countdown = m_in.period;
            if (!m_ff.phase[0]) begin
               m_in.steps_to_go = m_ff.steps_to_go - 32'd1;
               m_in.pos = (m_ff.dir == D_CCW) ? m_ff.pos - 32'd1 : m_ff.pos + 32'd1;
            end
            if (!m_ff.phase[0] && (m_ff.mode == M_STOP || m_ff.mode == M_ZSTOP)) begin
               m_in.coil_latch = 4'd0;
               m_in.steps_to_go = 32'd0;
               m_in.dir = D_STOPPED;
            end else if (m_ff.dir == D_CCW) begin
               m_in.phase = m_ff.phase - 3'd1;
            end else begin
               m_in.phase = m_ff.phase + 3'd1;
            end
         end
      end else if (go && selected) begin
         unique case (cmd_type'(command))
            CMD_MOVE, CMD_PULL: begin
               if (m_ff.dir != D_STOPPED) begin
                  status = ST_REJ;
               end else if (command == CMD_PULL && sw != 2'd0) begin
                  if (count[31] && sw[0]) status = ST_REJ;
                  else begin
                     ok = 1'b1;
                     m_in.dir = count[31] ? D_CCW : D_CW;
                     n = count[31] ? mag : count;
                     m_in.steps_at_switch = n;
                     m_in.mode = M_PULL;
                  end
               end else if (count[31]) begin
                  if (sw != 2'd0) status = ST_REJ;
                  else begin
                     ok = 1'b1;
                     m_in.dir = D_CCW;
                     n = mag;
                     m_in.mode = M_MOVE;
                  end
               end else begin
                  if (sw[1]) status = ST_REJ;
                  else begin
                     ok = 1'b1;
                     m_in.dir = D_CW;
                     m_in.mode = sw[0] ? M_PULL : M_MOVE;
                  end
               end
               if (ok) m_in.steps_to_go = n;
            end
            CMD_CCW: begin
               if (sw[0]) status = ST_LOWER;
               else begin
                  ok = 1'b1; m_in.mode = M_RUN; m_in.dir = D_CCW;
               end
            end
            CMD_CW: begin
               if (sw[1]) status = ST_UPPER;
               else begin
                  ok = 1'b1; m_in.mode = M_RUN; m_in.dir = D_CW;
               end
            end
            CMD_STOP:  m_in.mode = M_STOP;
            CMD_ZSTOP: m_in.mode = M_ZSTOP;
            default: ;
         endcase
         if (ok) begin
            m_in.coil_latch = coil_of(m_ff.phase);
            if (sp >= tgt) begin
               m_in.period = sp;
               m_in.ramp_step = 16'd1 + ((sp - tgt) >> RAMP_SHIFT);
            end else begin
               m_in.period = tgt;
               m_in.ramp_step = 16'd0;
            end
            m_in.countdown = m_in.period;
         end
      end
      // Supervision works on the state left by the tick or command.
      if (go) begin
         diff = $signed({m_in.steps_at_switch[31], m_in.steps_at_switch})
              - $signed({m_in.steps_to_go[31], m_in.steps_to_go});
         unique case (m_in.mode)
            M_PULL: begin
               if ($signed(m_in.steps_to_go) < 32'sd2) m_in.mode = M_STOP;
               else if (diff >= $signed({17'd0, pulloff})) m_in.mode = M_MOVE;
            end
            M_MOVE, M_RUN: begin
               if (m_in.mode == M_MOVE && $signed(m_in.steps_to_go) < 32'sd2)
                  m_in.mode = M_STOP;
               if (sw != 2'd0) begin
                  if (m_in.dir == D_CCW) begin
                     if (m_in.mode == M_RUN) begin
                        if (sw[0]) m_in.mode = M_ZSTOP;
                     end else begin
                        m_in.mode = M_STOP;
                     end
                  end else if (sw[1]) begin
                     m_in.mode = M_STOP;
                  end
               end
            end
            M_STOP:  if (m_in.dir == D_STOPPED) m_in.mode = M_RELAX;
            M_ZSTOP: if (m_in.dir == D_STOPPED) begin
               m_in.pos = 32'd0; m_in.mode = M_RELAX;
            end
            default: ;
         endcase
      end
      // A new target period takes effect at once as the present period.
      if (cfg_load) begin
         m_in.period = nz(cfg_value);
         m_in.ramp_step = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff <= '{mode: M_RELAX, dir: D_STOPPED, steps_to_go: 32'd0, pos: 32'd0,
                   steps_at_switch: 32'd0, ramp_step: 16'd0, phase: 3'd0,
                   period: RESET_TARGET, countdown: 16'd0, coil_latch: 4'd0};
      end else begin
         m_ff <= m_in;
      end
   end

   assign next_state = m_in;

   a_stopped_coils: assert property (@(posedge clock) disable iff (reset)
      (m_ff.dir != D_STOPPED) || $past(reset) || $past(m_ff.dir) != D_STOPPED
      || m_ff.coil_latch == $past(m_ff.coil_latch))
      else $error("coils changed while stopped");
   a_dir_legal: assert property (@(posedge clock) disable iff (reset)
      m_ff.dir != 2'd3) else $error("bad direction");
   a_count_run: assert property (@(posedge clock) disable iff (reset)
      m_ff.dir == D_STOPPED |=> m_ff.countdown == $past(m_ff.countdown)
      || $past(ok)) else $error("countdown moved while stopped");
endmodule

/* tb/stepper_halfstep_controller_unit_test.sv */
module stepper_halfstep_controller_unit_test;
   import shc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   stepper_halfstep_controller_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Motor state mirror.
   logic [2:0]  mot_mode [2];
   logic [1:0]  mot_dir [2];
   logic [31:0] mot_left [2];
   logic [31:0] mot_pos [2];
   logic [31:0] mot_at_switch [2];
   logic [15:0] mot_ramp [2];
   logic [15:0] mot_period [2];
   logic [15:0] mot_count [2];
   logic [2:0]  mot_phase [2];
   logic [3:0]  mot_coils [2];
   logic [15:0] target_per [2];
   logic [15:0] start_per;
   logic [15:0] pulloff_len;

   req_type pending_q [$];
   rsp_type rsp_expected_q [$];
   int      errors;
   logic    req_took;
   logic    no_idle;
   int      req_gap;
   int      rsp_gap;

   function automatic logic [3:0] halfstep_pattern(input logic [2:0] p);
      logic [3:0] pat [8];
      pat = '{4'b1000, 4'b1010, 4'b0010, 4'b0110, 4'b0100, 4'b0101, 4'b0001, 4'b1001};
      return pat[p];
   endfunction

   function automatic logic [15:0] at_least_one(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   function automatic void start_motor(input int m);
      logic [15:0] s;
      logic [15:0] t;
      s = at_least_one(start_per);
      t = at_least_one(target_per[m]);
      mot_coils[m] = halfstep_pattern(mot_phase[m]);
      if (s >= t) begin
         mot_period[m] = s;
         mot_ramp[m] = 16'd1 + (s - t) / 16'd64;
      end else begin
         mot_period[m] = t;
         mot_ramp[m] = 16'd0;
      end
      mot_count[m] = mot_period[m];
   endfunction

   function automatic void step_motor(input int m);
      logic [15:0] t;
      t = at_least_one(target_per[m]);
      if (mot_ramp[m] != 16'd0) begin
         if (mot_period[m] < mot_ramp[m] || (mot_period[m] - mot_ramp[m]) < t) begin
            mot_period[m] = t;
            mot_ramp[m] = 16'd0;
         end else begin
            mot_period[m] = mot_period[m] - mot_ramp[m];
         end
      end
      mot_coils[m] = halfstep_pattern(mot_phase[m]);
      if (mot_phase[m][0] == 1'b0) begin
         mot_left[m] = mot_left[m] - 32'd1;
         if (mot_dir[m] == D_CCW) mot_pos[m] = mot_pos[m] - 32'd1;
         else mot_pos[m] = mot_pos[m] + 32'd1;
         if (mot_mode[m] == M_STOP || mot_mode[m] == M_ZSTOP) begin
            mot_coils[m] = 4'd0;
            mot_left[m] = 32'd0;
            mot_dir[m] = D_STOPPED;
            return;
         end
      end
      if (mot_dir[m] == D_CCW) mot_phase[m] = mot_phase[m] - 3'd1;
      else mot_phase[m] = mot_phase[m] + 3'd1;
   endfunction

   function automatic logic [31:0] abs_sat(input logic [31:0] v);
      logic [31:0] a;
      a = 32'd0 - v;
      return (a == 32'h8000_0000) ? 32'h7FFF_FFFF : a;
   endfunction

   function automatic logic [1:0] begin_move(input int m, input logic [31:0] n,
                                             input logic [1:0] sw);
      if (mot_dir[m] != D_STOPPED) return ST_REJ;
      if (n[31]) begin
         if (sw != 2'd0) return ST_REJ;
         mot_dir[m] = D_CCW;
         n = abs_sat(n);
         mot_mode[m] = M_MOVE;
      end else begin
         if (sw[1]) return ST_REJ;
         mot_mode[m] = sw[0] ? M_PULL : M_MOVE;
         mot_dir[m] = D_CW;
      end
      mot_left[m] = n;
      start_motor(m);
      return ST_OK;
   endfunction

   function automatic logic [1:0] begin_pulloff(input int m, input logic [31:0] n,
                                                input logic [1:0] sw);
      if (mot_dir[m] != D_STOPPED) return ST_REJ;
      if (sw == 2'd0) return begin_move(m, n, sw);
      if (n[31]) begin
         if (sw[0]) return ST_REJ;
         mot_dir[m] = D_CCW;
         n = abs_sat(n);
      end else begin
         mot_dir[m] = D_CW;
      end
      mot_left[m] = n;
      mot_at_switch[m] = n;
      mot_mode[m] = M_PULL;
      start_motor(m);
      return ST_OK;
   endfunction

   function automatic void supervise_motor(input int m, input logic [1:0] sw);
      logic   ccw;
      longint left_s;
      ccw = (mot_dir[m] == D_CCW);
      left_s = longint'($signed(mot_left[m]));
      case (mot_mode[m])
         M_PULL: begin
            if (left_s < 2) mot_mode[m] = M_STOP;
            else if (longint'($signed(mot_at_switch[m])) - left_s >= longint'(pulloff_len))
               mot_mode[m] = M_MOVE;
         end
         M_MOVE, M_RUN: begin
            if (mot_mode[m] == M_MOVE && left_s < 2) mot_mode[m] = M_STOP;
            if (sw != 2'd0) begin
               if (ccw) begin
                  if (mot_mode[m] == M_RUN) begin
                     if (sw[0]) mot_mode[m] = M_ZSTOP;
                  end else begin
                     mot_mode[m] = M_STOP;
                  end
               end else if (sw[1]) begin
                  mot_mode[m] = M_STOP;
               end
            end
         end
         M_STOP: if (mot_dir[m] == D_STOPPED) mot_mode[m] = M_RELAX;
         M_ZSTOP: begin
            if (mot_dir[m] == D_STOPPED) begin
               mot_pos[m] = 32'd0;
               mot_mode[m] = M_RELAX;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_type controller_step(input req_type r);
      rsp_type     o;
      logic [1:0]  sw [2];
      logic [1:0]  st;
      int          sel;
      cmd_type     c;
      sw[0] = r.switches_0;
      sw[1] = r.switches_1;
      sel = r.motor_index;
      c = cmd_type'(r.command);
      st = ST_OK;
      case (c)
         CMD_TICK: begin
            for (int m = 0; m < 2; m++) begin
               if (mot_dir[m] != D_STOPPED) begin
                  if (mot_count[m] > 16'd1) mot_count[m] = mot_count[m] - 16'd1;
                  else begin
                     step_motor(m);
                     mot_count[m] = mot_period[m];
                  end
               end
            end
         end
         CMD_MOVE: st = begin_move(sel, r.step_count, sw[sel]);
         CMD_PULL: st = begin_pulloff(sel, r.step_count, sw[sel]);
         CMD_CCW: begin
            if (sw[sel][0]) st = ST_LOWER;
            else begin
               mot_mode[sel] = M_RUN;
               mot_dir[sel] = D_CCW;
               start_motor(sel);
            end
         end
         CMD_CW: begin
            if (sw[sel][1]) st = ST_UPPER;
            else begin
               mot_mode[sel] = M_RUN;
               mot_dir[sel] = D_CW;
               start_motor(sel);
            end
         end
         CMD_STOP: mot_mode[sel] = M_STOP;
         CMD_ZSTOP: mot_mode[sel] = M_ZSTOP;
         default: ;
      endcase
      for (int m = 0; m < 2; m++) supervise_motor(m, sw[m]);
      o.coils_0 = mot_coils[0];
      o.coils_1 = mot_coils[1];
      o.status = st;
      o.position = mot_pos[sel];
      o.steps_remaining = mot_left[sel];
      o.motor_mode = mot_mode[sel];
      o.direction = mot_dir[sel];
      o.current_period = mot_period[sel];
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Acceptance is recorded and each result is checked at the rising edge; the next
   // request and rsp_ready are driven at the falling edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && req_ready;
         if (req_valid && req_ready) rsp_expected_q.push_back(controller_step(req_data));
         if (rsp_valid && rsp_ready) begin
            if (rsp_expected_q.size() == 0) begin
               $display("%0t: unexpected result %0h", $time, rsp_data);
               errors++;
            end else begin
               want = rsp_expected_q.pop_front();
               check_field("coils_0", want.coils_0, rsp_data.coils_0);
               check_field("coils_1", want.coils_1, rsp_data.coils_1);
               check_field("status", want.status, rsp_data.status);
               check_field("position", want.position, rsp_data.position);
               check_field("steps_remaining", want.steps_remaining,
                           rsp_data.steps_remaining);
               check_field("motor_mode", want.motor_mode, rsp_data.motor_mode);
               check_field("direction", want.direction, rsp_data.direction);
               check_field("current_period", want.current_period, rsp_data.current_period);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_took) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_data <= pending_q.pop_front();
               req_valid <= 1'b1;
               if (!no_idle && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 9) == 0) rsp_gap = $urandom_range(1, 5);
         end
      end
   end

   task automatic wait_drained();
      while (pending_q.size() > 0 || req_valid || rsp_expected_q.size() > 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_TARGET_0, REG_TARGET_1: begin
            target_per[idx] = v;
            mot_period[idx] = at_least_one(v);
            mot_ramp[idx] = 16'd0;
         end
         REG_START: start_per = v;
         default: pulloff_len = v;
      endcase
   endtask

   task automatic push_req(input cmd_type c, input logic m, input logic [31:0] n,
                           input logic [1:0] s0, input logic [1:0] s1);
      req_type r;
      r.command = c;
      r.motor_index = m;
      r.step_count = n;
      r.switches_0 = s0;
      r.switches_1 = s1;
      pending_q.push_back(r);
   endtask

   task automatic push_ticks(input int count);
      for (int i = 0; i < count; i++) push_req(CMD_TICK, 1'b0, $urandom, 2'd0, 2'd0);
   endtask

   function automatic logic [31:0] pick_count();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'($urandom_range(0, 2)) - 32'd1;
         4, 5: return 32'd0 - 32'($urandom_range(1, 40));
         default: return 32'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic logic [1:0] pick_switches();
      return ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'd0;
   endfunction

   // One phase of random traffic: mostly commands followed by tick bursts so
   // that motors really run, ramp and reach their switches.
   task automatic random_phase(input int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         push_req(cmd_type'($urandom_range(1, 7)), 1'($urandom_range(0, 1)), pick_count(),
                  pick_switches(), pick_switches());
         sent++;
         if ($urandom_range(0, 2) != 0) begin
            int burst;
            burst = $urandom_range(1, 25);
            for (int i = 0; i < burst; i++)
               push_req(CMD_TICK, 1'($urandom_range(0, 1)), $urandom,
                        ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'd0,
                        ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'd0);
            sent += burst;
         end
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_TARGET_0;
      csr_wdata = 16'd0;
      req_gap = 0;
      rsp_gap = 0;
      no_idle = 1'b0;
      errors = 0;
      target_per[0] = 16'd1000;
      target_per[1] = 16'd1000;
      start_per = 16'd2000;
      pulloff_len = 16'd100;
      for (int m = 0; m < 2; m++) begin
         mot_mode[m] = M_RELAX;
         mot_dir[m] = D_STOPPED;
         mot_left[m] = 32'd0;
         mot_pos[m] = 32'd0;
         mot_at_switch[m] = 32'd0;
         mot_ramp[m] = 16'd0;
         mot_period[m] = 16'd1000;
         mot_count[m] = 16'd0;
         mot_phase[m] = 3'd0;
         mot_coils[m] = 4'd0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed requests at reset settings: every command, both switches and
      // the count extremes, including the largest negative count.
      push_req(CMD_QUERY, 1'b0, 32'd0, 2'd0, 2'd0);
      push_req(CMD_MOVE, 1'b0, 32'h8000_0000, 2'd0, 2'd0);
      push_req(CMD_MOVE, 1'b0, 32'd5, 2'd0, 2'd0);
      push_req(CMD_STOP, 1'b0, 32'd0, 2'd0, 2'd0);
      push_req(CMD_MOVE, 1'b1, 32'h7FFF_FFFF, 2'd3, 2'd2);
      push_req(CMD_MOVE, 1'b1, 32'h7FFF_FFFF, 2'd0, 2'd1);
      push_req(CMD_ZSTOP, 1'b1, 32'd0, 2'd0, 2'd0);
      push_req(CMD_CCW, 1'b0, 32'd0, 2'd1, 2'd0);
      push_req(CMD_CW, 1'b1, 32'd0, 2'd0, 2'd2);
      push_req(CMD_CCW, 1'b1, 32'hFFFF_FFFF, 2'd0, 2'd0);
      push_req(CMD_PULL, 1'b0, 32'hFFFF_FFFF, 2'd1, 2'd0);
      push_req(CMD_TICK, 1'b0, 32'd0, 2'd0, 2'd1);
      push_req(CMD_STOP, 1'b1, 32'd0, 2'd0, 2'd0);
      push_req(CMD_QUERY, 1'b1, 32'd0, 2'd3, 2'd3);
      wait_drained();

      // Fast timing so that steps, ramps and pull-offs happen often.
      write_reg(REG_TARGET_0, 16'd1);
      write_reg(REG_TARGET_1, 16'd2);
      write_reg(REG_START, 16'd9);
      write_reg(REG_PULLOFF, 16'd3);
      push_req(CMD_PULL, 1'b0, 32'd20, 2'd2, 2'd0);
      push_req(CMD_PULL, 1'b1, 32'hFFFF_FFF0, 2'd2, 2'd2);
      push_ticks(40);
      push_req(CMD_ZSTOP, 1'b0, 32'd0, 2'd0, 2'd0);
      push_ticks(10);
      random_phase(150);

      write_reg(REG_TARGET_0, 16'd0);
      write_reg(REG_TARGET_1, 16'd3);
      write_reg(REG_START, 16'd300);
      write_reg(REG_PULLOFF, 16'd0);
      random_phase(100);

      write_reg(REG_TARGET_0, 16'd65535);
      write_reg(REG_TARGET_1, 16'd1);
      write_reg(REG_START, 16'd0);
      write_reg(REG_PULLOFF, 16'd65535);
      random_phase(50);

      write_reg(REG_TARGET_0, 16'd2);
      write_reg(REG_TARGET_1, 16'd65535);
      write_reg(REG_START, 16'd65535);
      random_phase(40);

      write_reg(REG_TARGET_0, 16'd1);
      write_reg(REG_TARGET_1, 16'd1);
      write_reg(REG_START, 16'd6);
      write_reg(REG_PULLOFF, 16'd2);
      random_phase(80);

      no_idle = 1'b1;
      random_phase(80);

      repeat (5) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
